FILE: rtl/pisfd_pkg.sv
// Package: types and constants for the pulse interval sensor frame decoder.
`default_nettype none

package pisfd_pkg;

    localparam int COUNT_BITS = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS = 16;

    // Frame phase codes
    localparam logic [2:0] PH_IGNORE   = 3'd0;
    localparam logic [2:0] PH_RESPONSE = 3'd1;
    localparam logic [2:0] PH_DATA     = 3'd2;
    localparam logic [2:0] PH_FINISHED = 3'd3;
    localparam logic [2:0] PH_ERROR    = 3'd4;

    // Item action codes
    localparam logic ACT_ARM     = 1'b0;
    localparam logic ACT_CAPTURE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TIMER_PERIOD  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RESPONSE_MIN  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RESPONSE_MAX  = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ONE_THRESHOLD = 2'd3;

    // Configuration reset values
    localparam logic [COUNT_BITS-1:0] TIMER_PERIOD_RST  = 16'd65535;
    localparam logic [COUNT_BITS-1:0] RESPONSE_MIN_RST  = 16'd70;
    localparam logic [COUNT_BITS-1:0] RESPONSE_MAX_RST  = 16'd90;
    localparam logic [COUNT_BITS-1:0] ONE_THRESHOLD_RST = 16'd50;

    // Frame layout: four stored bytes, then the checksum byte
    localparam logic [2:0] LAST_BIT      = 3'd7;
    localparam logic [2:0] CHECKSUM_BYTE = 3'd4;

    typedef struct packed {
        logic                  action;
        logic [COUNT_BITS-1:0] capture_count;
        logic                  line_low;
    } item_t;

    typedef struct packed {
        logic [2:0] phase;
        logic [7:0] humidity_whole;
        logic [7:0] humidity_tenths;
        logic [7:0] temperature_whole;
        logic [7:0] temperature_tenths;
        logic       stop_timer;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/pulse_interval_sensor_frame_decoder.sv
// Top level: edge-capture frame decoder for a single-wire humidity/temperature sensor.
//
// Item channel (item_valid/item_ready/item): each transfer is either an arm
// command (action 0), which restarts the frame, or a capture event (action 1)
// with the latched timer count and the line level. Every item yields exactly
// one result on the result channel (result_valid/result_ready/result): the
// phase after the item, the four stored frame bytes and the stop flag.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the
// timer period, response window and one threshold; it is always ready and
// must only be used while no item is in flight.
// An item is first held in the input stage; its result is then registered in
// the result register once the result slot is free, and result_valid rises
// with it.
// Throughput: one item per cycle while the result is taken, set by the single
// compare and shift step between the input stage and the result register.
// Stalls: while result_ready is low the result holds; the input stage still
// takes one more item, after which item_ready drops until the result moves.
// Reset: both stages empty, phase ignore, counters and stored bytes zero,
// configuration registers at their default values.
`default_nettype none

module pulse_interval_sensor_frame_decoder
    import pisfd_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      item_valid,
    output logic                           item_ready,
    input  wire item_t                     item,
    output logic                           result_valid,
    input  wire logic                      result_ready,
    output result_t                        result,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

    // Configuration registers
    logic [COUNT_BITS-1:0] timer_period_reg;
    logic [COUNT_BITS-1:0] response_min_reg;
    logic [COUNT_BITS-1:0] response_max_reg;
    logic [COUNT_BITS-1:0] one_threshold_reg;

    // Input stage
    logic  stage_valid_reg;
    item_t stage_reg;

    // Frame state
    logic [2:0]            phase_reg,      phase_next;
    logic [COUNT_BITS-1:0] prev_count_reg, prev_count_next;
    logic [2:0]            bit_index_reg,  bit_index_next;
    logic [2:0]            byte_index_reg, byte_index_next;
    logic [7:0]            shift_byte_reg, shift_byte_next;
    logic [7:0]            frame_bytes_reg  [4];
    logic [7:0]            frame_bytes_next [4];

    // Result register
    logic    result_valid_reg;
    result_t result_reg, result_next;

    logic                  advance;
    logic [COUNT_BITS-1:0] interval;
    logic                  bit_val;
    logic [7:0]            shifted;
    logic [7:0]            byte_sum;
    logic                  in_window;

    assign cfg_ready = 1'b1;

    // The input stage moves into the result register when the result slot is
    // free or is being emptied this cycle.
    assign advance      = stage_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready   = !stage_valid_reg || advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_period_reg  <= TIMER_PERIOD_RST;
            response_min_reg  <= RESPONSE_MIN_RST;
            response_max_reg  <= RESPONSE_MAX_RST;
            one_threshold_reg <= ONE_THRESHOLD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TIMER_PERIOD:  timer_period_reg  <= cfg_data;
                CFG_RESPONSE_MIN:  response_min_reg  <= cfg_data;
                CFG_RESPONSE_MAX:  response_max_reg  <= cfg_data;
                CFG_ONE_THRESHOLD: one_threshold_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (item_ready)
            stage_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
            stage_reg <= item;
    end

    // Interval since the last capture; a count below the previous one means
    // the timer wrapped once at timer_period. Arithmetic wraps at COUNT_BITS.
    assign interval = (stage_reg.capture_count >= prev_count_reg)
                    ? stage_reg.capture_count - prev_count_reg
                    : timer_period_reg - prev_count_reg + stage_reg.capture_count
                      + COUNT_BITS'(1);

    assign bit_val   = interval > one_threshold_reg;
    assign shifted   = {shift_byte_reg[6:0], bit_val};
    assign byte_sum  = frame_bytes_reg[0] + frame_bytes_reg[1]
                     + frame_bytes_reg[2] + frame_bytes_reg[3];
    assign in_window = (interval >= response_min_reg) && (interval <= response_max_reg);

    always_comb
    begin
        phase_next      = phase_reg;
        prev_count_next = prev_count_reg;
        bit_index_next  = bit_index_reg;
        byte_index_next = byte_index_reg;
        shift_byte_next = shift_byte_reg;
        for (int i = 0; i < 4; i++)
            frame_bytes_next[i] = frame_bytes_reg[i];

        if (stage_reg.action == ACT_ARM)
        begin
            // Timer restarts from zero; stored bytes are kept.
            phase_next      = PH_IGNORE;
            prev_count_next = '0;
            bit_index_next  = '0;
            byte_index_next = '0;
            shift_byte_next = '0;
        end
        else if (phase_reg != PH_FINISHED && phase_reg != PH_ERROR)
        begin
            prev_count_next = stage_reg.capture_count;
            if (stage_reg.line_low)
            begin
                case (phase_reg)
                    PH_IGNORE:
                        phase_next = PH_RESPONSE;
                    PH_RESPONSE:
                    begin
                        if (in_window)
                        begin
                            phase_next      = PH_DATA;
                            bit_index_next  = '0;
                            byte_index_next = '0;
                        end
                        else
                            phase_next = PH_ERROR;
                    end
                    PH_DATA:
                    begin
                        shift_byte_next = shifted;
                        if (bit_index_reg != LAST_BIT)
                            bit_index_next = bit_index_reg + 3'd1;
                        else
                        begin
                            bit_index_next  = '0;
                            byte_index_next = byte_index_reg + 3'd1;
                            if (byte_index_reg < CHECKSUM_BYTE)
                                frame_bytes_next[byte_index_reg[1:0]] = shifted;
                            else if (byte_index_reg == CHECKSUM_BYTE)
                                phase_next = (shifted == byte_sum) ? PH_FINISHED
                                                                   : PH_ERROR;
                            else
                                phase_next = PH_ERROR;
                        end
                    end
                    default:
                        phase_next = PH_ERROR;
                endcase
            end
        end

        result_next.phase              = phase_next;
        result_next.humidity_whole     = frame_bytes_next[0];
        result_next.humidity_tenths    = frame_bytes_next[1];
        result_next.temperature_whole  = frame_bytes_next[2];
        result_next.temperature_tenths = frame_bytes_next[3];
        result_next.stop_timer         = (phase_next == PH_FINISHED)
                                      || (phase_next == PH_ERROR);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IGNORE;
            prev_count_reg <= '0;
            bit_index_reg  <= '0;
            byte_index_reg <= '0;
            shift_byte_reg <= '0;
            for (int i = 0; i < 4; i++)
                frame_bytes_reg[i] <= '0;
        end
        else if (advance)
        begin
            phase_reg      <= phase_next;
            prev_count_reg <= prev_count_next;
            bit_index_reg  <= bit_index_next;
            byte_index_reg <= byte_index_next;
            shift_byte_reg <= shift_byte_next;
            for (int i = 0; i < 4; i++)
                frame_bytes_reg[i] <= frame_bytes_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

endmodule

`default_nettype wire

FILE: rtl/pisfd_checker.sv
// Port-level checker for the frame decoder, bound to the top level.
`default_nettype none

module pisfd_checker
    import pisfd_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      item_valid,
    input wire logic                      item_ready,
    input wire logic                      result_valid,
    input wire logic                      result_ready,
    input wire result_t                   result
);

    // Stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // Stop flag tracks the terminal phases
    a_stop_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.stop_timer ==
            ((result.phase == PH_FINISHED) || (result.phase == PH_ERROR)))
        else $error("stop flag inconsistent with phase");

    // No result is valid while reset is asserted
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !result_valid)
        else $error("result valid during reset");

    // A full pipeline with a stalled receiver takes nothing more
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && result_valid && !result_ready
        |=> !result_ready |-> !item_ready)
        else $error("item taken with both stages full");

endmodule

bind pulse_interval_sensor_frame_decoder pisfd_checker u_pisfd_checker (.*);

`default_nettype wire
